// ===== rtl/dlsm_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsm_pkg
// Shared types, codes and sizes of the dual link sequence merge.
// ----------------------------------------------------------------------------
package dlsm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TYPE_COUNT  = 8;
    localparam int QAW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);
    localparam int TW          = 3;
    localparam logic [31:0] INITIAL_SEQ = 32'd1;
    localparam logic [15:0] LAG_RESET   = 16'd10;

    // input commands
    localparam logic [1:0] CMD_PUSH_PRI = 2'd0;
    localparam logic [1:0] CMD_PUSH_BAK = 2'd1;
    localparam logic [1:0] CMD_POLL     = 2'd2;

    // register index
    localparam logic REG_LIMIT_LAG = 1'b0;

    typedef struct packed {
        logic [31:0]   seq;
        logic [TW-1:0] ptype;
        logic [15:0]   tag;
    } t_entry;

    typedef struct packed {
        logic push;
        logic push_fifo;
        logic emit_front;
        logic emit_scan;
        logic take_front;
        logic drop_scan;
        logic e_set_s1;
        logic e_set_one;
        logic latch_flush;
        logic scan_next;
        logic scan_switch;
        logic use_saved;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic both_ne;
        logic any_ne;
        logic out_free;
        logic pend_valid;
        logic s_ge_e;
        logic s_eq_e;
        logic s_lt_e;
        logic lagged;
        logic fill_lt_lag;
        logic scan_end;
        logic scan_match;
        logic scan_ge_e;
        logic scan_fifo;
    } t_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MERGE,
        S_DRAIN,
        S_FLUSH,
        S_FLUSH_LAST,
        S_FINISH
    } t_state;

endpackage

// ===== rtl/dlsm_if.sv =====
// ----------------------------------------------------------------------------
// dlsm_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dlsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] seq_number;
    logic [2:0]  packet_type;
    logic [15:0] packet_tag;

    modport source (output valid, command, seq_number, packet_type, packet_tag,
                    input ready);
    modport sink   (input valid, command, seq_number, packet_type, packet_tag,
                    output ready);
endinterface

interface dlsm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_seq_number;
    logic [2:0]  out_type;
    logic [15:0] out_tag;
    logic        last;

    modport source (output valid, out_seq_number, out_type, out_tag, last,
                    input ready);
    modport sink   (input valid, out_seq_number, out_type, out_tag, last,
                    output ready);
endinterface

// ===== rtl/dual_link_sequence_merge.sv =====
// Push: accepted while idle; the block is ready again in the next cycle.
// Poll: one merge, drain or flush-scan step per cycle while the output register is
//   free; a sender-reset flush scans the primary, then the backup FIFO.
// Each result waits in a pending register until the next result or the poll end
//   moves it to the output register; only the poll end sets its last flag.
// Reset (synchronous, active low): FIFOs empty, counters at one, limit_lag 10.
// ----------------------------------------------------------------------------
// dual_link_sequence_merge
// Ordered duplicate-free merge of primary and backup link packet headers.
// ----------------------------------------------------------------------------
module dual_link_sequence_merge
    import dlsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlsm_in_if.sink     i_in,
    dlsm_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd        cmd;
    t_stat       stat;
    t_entry      push_entry;
    t_entry      out_entry;
    logic [15:0] lag;
    logic        cfg_we;

    // single register, selected by paddr[2] low (addresses 0 to 3); other addresses ignored
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_LIMIT_LAG);
    assign prdata = (paddr[2] == REG_LIMIT_LAG) ? {16'd0, lag} : 32'd0;

    assign push_entry.seq   = i_in.seq_number;
    assign push_entry.ptype = i_in.packet_type;
    assign push_entry.tag   = i_in.packet_tag;

    // sequencer: accepts items only when idle, walks the FIFOs during a poll
    dlsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_command  (i_in.command),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // storage and compare logic; each result is held back in a pending register
    // so that the last flag can be set when the poll ends
    dlsm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_push_entry (push_entry),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (pwdata[15:0]),
        .o_lag        (lag),
        .o_stat       (stat),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_entry  (out_entry),
        .o_out_last   (o_out.last)
    );

    assign o_out.out_seq_number = out_entry.seq;
    assign o_out.out_type       = out_entry.ptype;
    assign o_out.out_tag        = out_entry.tag;

endmodule

// ===== rtl/dlsm_datapath.sv =====
// ----------------------------------------------------------------------------
// dlsm_datapath
// Link FIFOs, expected counters, lag register, pending and output registers.
// ----------------------------------------------------------------------------
module dlsm_datapath
    import dlsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_entry      i_push_entry,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic [15:0] o_lag,
    output t_stat       o_stat,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_entry      o_out_entry,
    output logic        o_out_last
);

    t_entry            r_q0 [QUEUE_DEPTH];
    t_entry            r_q1 [QUEUE_DEPTH];
    logic [QCW-1:0]    r_fill0, r_fill1;
    logic [31:0]       r_exp [TYPE_COUNT];
    logic [15:0]       r_lag;
    logic              r_sel;
    logic [TW-1:0]     r_t;
    logic              r_scan_fifo;
    logic [QCW-1:0]    r_scan_idx;
    t_entry            r_pend;
    logic              r_pend_valid;
    t_entry            r_out;
    logic              r_out_valid;
    logic              r_out_last;

    logic              both_ne, any_ne, sel_live, sel;
    t_entry            front, scan_e, emit_e;
    logic [QCW-1:0]    fill_sel, scan_fill;
    logic [TW-1:0]     etype;
    logic [31:0]       e_cur;
    logic              out_free, emit;
    logic              drop0, drop1;
    logic [QCW-1:0]    idx0, idx1;

    assign both_ne  = (r_fill0 != '0) && (r_fill1 != '0);
    assign any_ne   = (r_fill0 != '0) || (r_fill1 != '0);
    assign sel_live = both_ne ? (r_q0[0].seq > r_q1[0].seq) : (r_fill0 == '0);
    assign sel      = i_cmd.use_saved ? r_sel : sel_live;
    assign front    = sel ? r_q1[0] : r_q0[0];
    assign fill_sel = sel ? r_fill1 : r_fill0;
    assign etype    = i_cmd.use_saved ? r_t : front.ptype;
    assign e_cur    = r_exp[etype];
    assign scan_e   = r_scan_fifo ? r_q1[r_scan_idx[QAW-1:0]] : r_q0[r_scan_idx[QAW-1:0]];
    assign scan_fill = r_scan_fifo ? r_fill1 : r_fill0;
    assign out_free = !r_out_valid || i_out_ready;
    assign emit     = i_cmd.emit_front || i_cmd.emit_scan;
    assign emit_e   = i_cmd.emit_scan ? scan_e : front;

    // deletes: take_front removes index 0 of the selected FIFO, flush the scan slot
    assign drop0 = (i_cmd.take_front && !sel) || (i_cmd.drop_scan && !r_scan_fifo);
    assign drop1 = (i_cmd.take_front && sel) || (i_cmd.drop_scan && r_scan_fifo);
    assign idx0  = i_cmd.drop_scan ? r_scan_idx : '0;
    assign idx1  = i_cmd.drop_scan ? r_scan_idx : '0;

    always_comb begin
        o_stat.both_ne     = both_ne;
        o_stat.any_ne      = any_ne;
        o_stat.out_free    = out_free;
        o_stat.pend_valid  = r_pend_valid;
        o_stat.s_ge_e      = front.seq >= e_cur;
        o_stat.s_eq_e      = front.seq == e_cur;
        o_stat.s_lt_e      = front.seq < e_cur;
        o_stat.lagged      = ({1'b0, front.seq} + {17'd0, r_lag}) < {1'b0, e_cur};
        o_stat.fill_lt_lag = {{(16-QCW){1'b0}}, fill_sel} < r_lag;
        o_stat.scan_end    = r_scan_idx >= scan_fill;
        o_stat.scan_match  = scan_e.ptype == r_t;
        o_stat.scan_ge_e   = scan_e.seq >= e_cur;
        o_stat.scan_fifo   = r_scan_fifo;
    end

    // FIFO payload, no reset
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
            if (drop0 && (QCW'(j) >= idx0)) r_q0[j] <= r_q0[j+1];
            if (drop1 && (QCW'(j) >= idx1)) r_q1[j] <= r_q1[j+1];
        end
        if (i_cmd.push && !i_cmd.push_fifo && r_fill0 < QCW'(QUEUE_DEPTH)) begin
            r_q0[r_fill0[QAW-1:0]] <= i_push_entry;
        end
        if (i_cmd.push && i_cmd.push_fifo && r_fill1 < QCW'(QUEUE_DEPTH)) begin
            r_q1[r_fill1[QAW-1:0]] <= i_push_entry;
        end
        if (i_cmd.latch_flush) begin
            r_sel <= sel_live;
            r_t   <= front.ptype;
        end
        if (emit) r_pend <= emit_e;
        if ((emit && r_pend_valid) || i_cmd.finish) r_out <= r_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill0      <= '0;
            r_fill1      <= '0;
            for (int k = 0; k < TYPE_COUNT; k++) r_exp[k] <= INITIAL_SEQ;
            r_lag        <= LAG_RESET;
            r_scan_fifo  <= 1'b0;
            r_scan_idx   <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            if (i_cfg_we) r_lag <= i_cfg_wdata;
            if (i_cmd.push && !i_cmd.push_fifo && r_fill0 < QCW'(QUEUE_DEPTH)) begin
                r_fill0 <= r_fill0 + 1'b1;
            end else if (drop0) begin
                r_fill0 <= r_fill0 - 1'b1;
            end
            if (i_cmd.push && i_cmd.push_fifo && r_fill1 < QCW'(QUEUE_DEPTH)) begin
                r_fill1 <= r_fill1 + 1'b1;
            end else if (drop1) begin
                r_fill1 <= r_fill1 - 1'b1;
            end
            if (i_cmd.e_set_s1) r_exp[etype] <= front.seq + 32'd1;
            if (i_cmd.e_set_one) r_exp[etype] <= INITIAL_SEQ;
            if (i_cmd.latch_flush) begin
                r_scan_fifo <= 1'b0;
                r_scan_idx  <= '0;
            end else if (i_cmd.scan_switch) begin
                r_scan_fifo <= 1'b1;
                r_scan_idx  <= '0;
            end else if (i_cmd.scan_next) begin
                r_scan_idx  <= r_scan_idx + 1'b1;
            end
            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if ((emit && r_pend_valid) || i_cmd.finish) begin
                r_out_valid <= 1'b1;
                r_out_last  <= i_cmd.finish;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_lag       = r_lag;
    assign o_out_valid = r_out_valid;
    assign o_out_entry = r_out;
    assign o_out_last  = r_out_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill0 <= QCW'(QUEUE_DEPTH)) && (r_fill1 <= QCW'(QUEUE_DEPTH)))
        else $error("fifo fill beyond depth");
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !r_pend_valid && r_out_valid && r_out_last)
        else $error("finish did not flush pending item");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit || i_cmd.finish) && r_pend_valid |-> out_free)
        else $error("output register overwritten");
    a_push_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !emit && !drop0 && !drop1)
        else $error("push during merge step");

endmodule

// ===== rtl/dlsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlsm_ctrl
// Merge sequencer: one merge, drain or flush step per cycle while the output register is free.
// ----------------------------------------------------------------------------
module dlsm_ctrl
    import dlsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_command,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_command == CMD_POLL) n_state = S_MERGE;
            end
            S_MERGE: begin
                if (i_stat.out_free) begin
                    if (!i_stat.both_ne) n_state = S_DRAIN;
                    else if (!i_stat.s_ge_e && i_stat.lagged) n_state = S_FLUSH;
                end
            end
            S_DRAIN: begin
                if (i_stat.out_free) begin
                    if (!i_stat.any_ne) n_state = S_FINISH;
                    else if (!i_stat.s_lt_e && !i_stat.s_eq_e && i_stat.fill_lt_lag)
                        n_state = S_FINISH;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free && (i_stat.scan_end ||
                        (i_stat.scan_match && !i_stat.scan_ge_e)) && i_stat.scan_fifo)
                    n_state = S_FLUSH_LAST;
            end
            S_FLUSH_LAST: begin
                if (i_stat.out_free) n_state = S_MERGE;
            end
            S_FINISH: begin
                if (!i_stat.pend_valid || i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.push     = i_in_valid &&
                                 (i_command == CMD_PUSH_PRI || i_command == CMD_PUSH_BAK);
                o_cmd.push_fifo = (i_command == CMD_PUSH_BAK);
            end
            S_MERGE: begin
                if (i_stat.out_free && i_stat.both_ne) begin
                    if (i_stat.s_ge_e) begin
                        o_cmd.emit_front = 1'b1;
                        o_cmd.e_set_s1   = 1'b1;
                        o_cmd.take_front = 1'b1;
                    end else if (i_stat.lagged) begin
                        o_cmd.latch_flush = 1'b1;
                    end else begin
                        o_cmd.take_front = 1'b1;
                    end
                end
            end
            S_DRAIN: begin
                if (i_stat.out_free && i_stat.any_ne) begin
                    if (i_stat.s_lt_e) begin
                        o_cmd.emit_front = i_stat.lagged;
                        o_cmd.e_set_s1   = i_stat.lagged;
                        o_cmd.take_front = 1'b1;
                    end else if (i_stat.s_eq_e || !i_stat.fill_lt_lag) begin
                        o_cmd.emit_front = 1'b1;
                        o_cmd.e_set_s1   = 1'b1;
                        o_cmd.take_front = 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.use_saved = 1'b1;
                if (i_stat.out_free) begin
                    if (i_stat.scan_end || (i_stat.scan_match && !i_stat.scan_ge_e)) begin
                        o_cmd.scan_switch = !i_stat.scan_fifo;
                    end else if (i_stat.scan_match) begin
                        o_cmd.emit_scan = 1'b1;
                        o_cmd.drop_scan = 1'b1;
                    end else begin
                        o_cmd.scan_next = 1'b1;
                    end
                end
            end
            S_FLUSH_LAST: begin
                o_cmd.use_saved = 1'b1;
                if (i_stat.out_free) begin
                    o_cmd.emit_front = 1'b1;
                    o_cmd.e_set_one  = 1'b1;
                    o_cmd.take_front = 1'b1;
                end
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.pend_valid && i_stat.out_free;
            end
            default: ;
        endcase
    end

endmodule
